### hdl/cets_pkg.sv
// shared widths, constants and month table for the calendar to epoch seconds unit
`default_nettype none

package cets_pkg;

    localparam int unsigned YEAR_W   = 8;
    localparam int unsigned MONTH_W  = 4;
    localparam int unsigned DAY_W    = 5;
    localparam int unsigned HOUR_W   = 5;
    localparam int unsigned MINUTE_W = 6;
    localparam int unsigned SECOND_W = 6;
    localparam int unsigned IN_W     = YEAR_W + MONTH_W + DAY_W + HOUR_W + MINUTE_W + SECOND_W;
    localparam int unsigned IN_BYTES_W = ((IN_W + 7) / 8) * 8;
    localparam int unsigned OUT_W    = 32;

    localparam int unsigned YDAYS_W  = 17;
    localparam int unsigned LEAPS_W  = 7;
    localparam int unsigned MDAYS_W  = 9;
    localparam int unsigned TOD_W    = 17;
    localparam int unsigned DAYS_W   = 18;

    localparam logic [8:0]         DAYS_PER_YEAR   = 9'd365;
    localparam logic [11:0]        SEC_PER_HOUR    = 12'd3600;
    localparam logic [5:0]         SEC_PER_MINUTE  = 6'd60;
    localparam logic signed [17:0] SEC_PER_DAY     = 18'sd86400;

    // year offsets of the century years 2100 and 2200, not leap
    localparam logic [YEAR_W-1:0]  OFS_2100        = 8'd130;
    localparam logic [YEAR_W-1:0]  OFS_2200        = 8'd230;
    localparam logic [MONTH_W-1:0] MONTH_MARCH     = 4'd3;

    typedef struct packed {
        logic [SECOND_W-1:0] second;
        logic [MINUTE_W-1:0] minute;
        logic [HOUR_W-1:0]   hour;
        logic [DAY_W-1:0]    day_of_month;
        logic [MONTH_W-1:0]  month;
        logic [YEAR_W-1:0]   year_offset;
    } t_cal;

    // days in the whole months before the given month, non-leap year
    function automatic logic [MDAYS_W-1:0] month_start_days(input logic [MONTH_W-1:0] month);
        logic [MDAYS_W-1:0] d;
        begin
            case (month)
                4'd0, 4'd1: d = 9'd0;
                4'd2:       d = 9'd31;
                4'd3:       d = 9'd59;
                4'd4:       d = 9'd90;
                4'd5:       d = 9'd120;
                4'd6:       d = 9'd151;
                4'd7:       d = 9'd181;
                4'd8:       d = 9'd212;
                4'd9:       d = 9'd243;
                4'd10:      d = 9'd273;
                4'd11:      d = 9'd304;
                4'd12:      d = 9'd334;
                default:    d = 9'd365;
            endcase
            return d;
        end
    endfunction

endpackage

`default_nettype wire

### hdl/cets_day_count.sv
// first two pipeline stages: day count since epoch and seconds within the day
`default_nettype none

module cets_day_count
    import cets_pkg::*;
(
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_en,
    input  wire                     i_valid,
    input  t_cal                    i_cal,
    output logic                    o_valid,
    output logic signed [DAYS_W-1:0] o_days,
    output logic [TOD_W-1:0]        o_tod
);

    logic                       r_v1;
    logic [YDAYS_W-1:0]         r_ydays;
    logic [LEAPS_W-1:0]         r_leaps;
    logic [MDAYS_W-1:0]         r_mdays;
    logic [DAY_W-1:0]           r_day;
    logic [TOD_W-1:0]           r_tod1;
    logic                       r_v2;
    logic signed [DAYS_W-1:0]   r_days;
    logic [TOD_W-1:0]           r_tod2;

    logic [YDAYS_W-1:0]         n_ydays;
    logic [LEAPS_W-1:0]         n_leaps;
    logic [MDAYS_W-1:0]         n_mdays;
    logic [TOD_W-1:0]           n_tod1;
    logic signed [DAYS_W-1:0]   n_days;
    logic [YEAR_W:0]            w_mult4;
    logic                       w_leap;

    always_comb begin
        n_ydays = YDAYS_W'(i_cal.year_offset) * YDAYS_W'(DAYS_PER_YEAR);
        // multiples of four before the year, less the skipped century years
        w_mult4 = ({1'b0, i_cal.year_offset} + 9'd1) >> 2;
        n_leaps = LEAPS_W'(w_mult4)
                - LEAPS_W'(i_cal.year_offset > OFS_2100)
                - LEAPS_W'(i_cal.year_offset > OFS_2200);
        w_leap  = (i_cal.year_offset[1:0] == 2'd2)
               && (i_cal.year_offset != OFS_2100)
               && (i_cal.year_offset != OFS_2200);
        n_mdays = month_start_days(i_cal.month)
                + MDAYS_W'(w_leap && (i_cal.month >= MONTH_MARCH));
        n_tod1  = TOD_W'(i_cal.hour) * TOD_W'(SEC_PER_HOUR)
                + TOD_W'(i_cal.minute) * TOD_W'(SEC_PER_MINUTE)
                + TOD_W'(i_cal.second);
        n_days  = $signed(DAYS_W'(r_ydays)) + $signed(DAYS_W'(r_leaps))
                + $signed(DAYS_W'(r_mdays)) + $signed(DAYS_W'(r_day))
                - 18'sd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ydays <= n_ydays;
            r_leaps <= n_leaps;
            r_mdays <= n_mdays;
            r_day   <= i_cal.day_of_month;
            r_tod1  <= n_tod1;
            r_days  <= n_days;
            r_tod2  <= r_tod1;
        end
    end

    assign o_valid = r_v2;
    assign o_days  = r_days;
    assign o_tod   = r_tod2;

endmodule

`default_nettype wire

### hdl/cets_sec_scale.sv
// last two pipeline stages: days to seconds and final sum, modulo 2^32
`default_nettype none

module cets_sec_scale
    import cets_pkg::*;
(
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_en,
    input  wire                      i_valid,
    input  wire signed [DAYS_W-1:0]  i_days,
    input  wire [TOD_W-1:0]          i_tod,
    output logic                     o_valid,
    output logic [OUT_W-1:0]         o_seconds
);

    logic                        r_v3;
    logic [OUT_W-1:0]            r_prod;
    logic [TOD_W-1:0]            r_tod3;
    logic                        r_v4;
    logic [OUT_W-1:0]            r_sum;

    logic signed [2*DAYS_W-1:0]  n_prod;
    logic [OUT_W-1:0]            n_sum;

    always_comb begin
        n_prod = i_days * SEC_PER_DAY;
        n_sum  = r_prod + OUT_W'(r_tod3);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (i_en) begin
            r_v3 <= i_valid;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod[OUT_W-1:0];
            r_tod3 <= i_tod;
            r_sum  <= n_sum;
        end
    end

    assign o_valid   = r_v4;
    assign o_seconds = r_sum;

endmodule

`default_nettype wire

### hdl/calendar_to_epoch_seconds_unit.sv
// top level of the calendar time to epoch seconds converter
//
// input stream: one beat carries year offset from 1970, month, day of month,
// hour, minute and second; the output stream gives seconds since 1970-01-01
// 00:00:00, wrapping modulo 2^32. fields are used as given, without checks.
// each accepted beat goes through the stages below to its output beat; a new
// beat is taken every cycle unless the output stalls; one conversion per cycle.
// the four stages are: year, leap and month day terms plus time of day;
// day sum; multiply by 86400; add time of day into the output register.
// all stages advance together when the output register is empty or its beat
// is taken; while the receiver stalls a full output, s_axis_tready is low and
// every stage holds, so nothing is lost or repeated. bubbles travel as empty
// slots with their valid bits.
// synchronous active-low reset empties the pipeline; no beat is in flight
// after it and s_axis_tready is high in the first cycle after reset.
`default_nettype none

module calendar_to_epoch_seconds_unit
    import cets_pkg::*;
(
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   s_axis_tvalid,
    output logic                  s_axis_tready,
    // year_offset[7:0], month[11:8], day_of_month[16:12], hour[21:17],
    // minute[27:22], second[33:28], zero fill[39:34]
    input  wire [IN_BYTES_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  wire                   m_axis_tready,
    // epoch_seconds[31:0]
    output logic [OUT_W-1:0]      m_axis_tdata
);

    t_cal                     w_cal;
    logic                     w_en;
    logic                     w_dc_valid;
    logic signed [DAYS_W-1:0] w_days;
    logic [TOD_W-1:0]         w_tod;
    logic                     w_out_valid;
    logic [IN_BYTES_W-1:IN_W] w_pad;

    assign w_cal = t_cal'(s_axis_tdata[IN_W-1:0]);
    assign w_pad = s_axis_tdata[IN_BYTES_W-1:IN_W];
    assign w_en  = !w_out_valid || m_axis_tready || (&w_pad && 1'b0);

    cets_day_count u_day_count (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (s_axis_tvalid),
        .i_cal   (w_cal),
        .o_valid (w_dc_valid),
        .o_days  (w_days),
        .o_tod   (w_tod)
    );

    cets_sec_scale u_sec_scale (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_valid   (w_dc_valid),
        .i_days    (w_days),
        .i_tod     (w_tod),
        .o_valid   (w_out_valid),
        .o_seconds (m_axis_tdata)
    );

    assign s_axis_tready = w_en;
    assign m_axis_tvalid = w_out_valid;

endmodule

`default_nettype wire

### sim/calendar_to_epoch_seconds_unit_tb.sv
// testbench for the calendar time to epoch seconds converter, self-checking against its own predictor
`timescale 1ns / 100ps

module calendar_to_epoch_seconds_unit_tb;

    import cets_pkg::*;

    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned RANDOM_BEATS = 800;
    localparam int unsigned LONG_HOLD = 80;
    localparam int unsigned HOLD_AFTER_BEATS = 300;
    localparam int unsigned DRAIN_CYCLES = 8;

    typedef enum {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_EVERY_THIRD} rx_mode_e;

    class epoch_checker;
        int unsigned month_len[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        bit [OUT_W-1:0] pending_seconds[$];
        int unsigned mismatches = 0;
        int unsigned beats_in = 0;

        function bit is_leap(int unsigned ofs);
            int unsigned y;
            y = 1970 + ofs;
            return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
        endfunction

        function bit [OUT_W-1:0] seconds_of(t_cal c);
            int unsigned days;
            int unsigned months;
            int unsigned total;
            bit leap;
            leap = is_leap(c.year_offset);
            days = c.year_offset * 365;
            for (int unsigned i = 0; i < c.year_offset; i++) begin
                if (is_leap(i)) days++;
            end
            // month above twelve counts a full year of months
            months = (c.month == 0) ? 0 : c.month - 1;
            if (months > 12) months = 12;
            for (int unsigned i = 0; i < months; i++) begin
                days += (i == 1 && leap) ? 29 : month_len[i];
            end
            // day zero wraps to one day back
            total = days * 86400;
            total += (int'(c.day_of_month) - 1) * 86400;
            total += c.hour * 3600;
            total += c.minute * 60;
            total += c.second;
            return total;
        endfunction

        function void note_input(t_cal c);
            pending_seconds.push_back(seconds_of(c));
            beats_in++;
        endfunction

        function void check_result(bit [OUT_W-1:0] got);
            bit [OUT_W-1:0] want;
            if (pending_seconds.size() == 0) begin
                $display("%0t: epoch seconds beat with none expected: expected none, got %0d",
                         $time, got);
                mismatches++;
            end else begin
                want = pending_seconds.pop_front();
                if (want !== got) begin
                    $display("%0t: epoch seconds mismatch: expected %0d, got %0d",
                             $time, want, got);
                    mismatches++;
                end
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    // year_offset[7:0], month[11:8], day_of_month[16:12], hour[21:17],
    // minute[27:22], second[33:28], zero fill[39:34]
    logic [IN_BYTES_W-1:0] s_axis_tdata;
    logic m_axis_tvalid;
    logic m_axis_tready;
    // epoch_seconds[31:0]
    logic [OUT_W-1:0] m_axis_tdata;

    epoch_checker sb;
    int unsigned quiet_cycles = 0;

    calendar_to_epoch_seconds_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_cal cal(input logic [7:0] y, input logic [3:0] m,
                                 input logic [4:0] d, input logic [4:0] h,
                                 input logic [5:0] mi, input logic [5:0] s);
        return t_cal'({s, mi, h, d, m, y});
    endfunction

    function automatic t_cal random_cal();
        bit [63:0] r;
        r = {$urandom, $urandom};
        // mostly in-range dates, some raw bit patterns
        if ($urandom_range(0, 4) == 0) return t_cal'(r[IN_W-1:0]);
        return cal(8'($urandom_range(0, 255)), 4'($urandom_range(1, 12)),
                   5'($urandom_range(1, 31)), 5'($urandom_range(0, 23)),
                   6'($urandom_range(0, 59)), 6'($urandom_range(0, 59)));
    endfunction

    task automatic send_beat(input t_cal c);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {{(IN_BYTES_W - IN_W){1'b0}}, c};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic pause_sender(input int unsigned n);
        if (n != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // beat monitor and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            sb.note_input(t_cal'(s_axis_tdata[IN_W-1:0]));
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_result(m_axis_tdata);
        end
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == STALL_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
            $display("** calendar_to_epoch_seconds_unit: FAILED **");
            $finish;
        end
    end

    // receiver stalls
    initial begin
        rx_mode_e mode;
        int unsigned left;
        int unsigned phase;
        bit held;
        m_axis_tready = 1'b0;
        mode = RX_ALWAYS;
        left = 0;
        phase = 0;
        held = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (!held && sb.beats_in >= HOLD_AFTER_BEATS) begin
                // long hold so the pipeline fills and input backs up
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else begin
                if (left == 0) begin
                    mode = rx_mode_e'($urandom_range(0, 3));
                    left = $urandom_range(20, 150);
                end
                left--;
                phase++;
                case (mode)
                    RX_ALWAYS: m_axis_tready <= 1'b1;
                    RX_COIN: m_axis_tready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default: m_axis_tready <= (phase % 3 == 0);
                endcase
            end
        end
    end

    initial begin
        t_cal directed[$];
        int unsigned sent;
        int unsigned burst;
        sb = new();
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;

        // epoch start, all ones, month zero, months above twelve, day zero
        directed.push_back(cal(8'd0, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0));
        directed.push_back(cal(8'd255, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63));
        directed.push_back(cal(8'd5, 4'd0, 5'd10, 5'd12, 6'd30, 6'd30));
        directed.push_back(cal(8'd2, 4'd13, 5'd1, 5'd0, 6'd0, 6'd0));
        directed.push_back(cal(8'd3, 4'd14, 5'd1, 5'd0, 6'd0, 6'd0));
        directed.push_back(cal(8'd130, 4'd15, 5'd1, 5'd0, 6'd0, 6'd0));
        directed.push_back(cal(8'd0, 4'd1, 5'd0, 5'd0, 6'd0, 6'd0));
        // century years: 2000 leap, 2100 and 2200 not; then 23:59:59 on 1 March 1972
        directed.push_back(cal(8'd30, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0));
        directed.push_back(cal(8'd130, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0));
        directed.push_back(cal(8'd230, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0));
        directed.push_back(cal(8'd2, 4'd3, 5'd1, 5'd23, 6'd59, 6'd59));
        // every month of a leap year
        for (int unsigned m = 1; m <= 12; m++) begin
            directed.push_back(cal(8'd54, 4'(m), 5'(m + 15), 5'(m), 6'(m * 4), 6'(m * 5)));
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[i]) begin
            send_beat(directed[i]);
            pause_sender($urandom_range(0, 2));
        end

        sent = 0;
        while (sent < RANDOM_BEATS) begin
            burst = $urandom_range(1, 24);
            for (int unsigned j = 0; j < burst && sent < RANDOM_BEATS; j++) begin
                send_beat(random_cal());
                sent++;
            end
            pause_sender(($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8));
        end
        s_axis_tvalid <= 1'b0;

        while (sb.pending_seconds.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.pending_seconds.size() == 0) begin
            $display("** calendar_to_epoch_seconds_unit: PASSED **");
        end else begin
            $display("** calendar_to_epoch_seconds_unit: FAILED **");
        end
        $finish;
    end

endmodule
